### hdl/fp4dq_pkg.sv
`default_nettype none
package fp4dq_pkg;
	localparam int unsigned BYTES_PER_BLOCK = 8;
	localparam int unsigned NUM_WORDS = 8;

	typedef logic [15:0] bf16_t;

	// Scale decoded into sign, unbiased exponent offset and significand.
	typedef struct packed {
		logic       sign;
		logic [4:0] expo;
		logic [3:0] sig;
		logic       zero;
	} scale_t;

	// e2m1 magnitude in half units: sig * 2^sh.
	function automatic logic [2:0] fp4_sig(input logic [2:0] code);
		case (code)
			3'd0:    fp4_sig = 3'd0;
			3'd1:    fp4_sig = 3'd1;
			3'd2:    fp4_sig = 3'd1;
			3'd3:    fp4_sig = 3'd3;
			3'd4:    fp4_sig = 3'd1;
			3'd5:    fp4_sig = 3'd3;
			3'd6:    fp4_sig = 3'd1;
			3'd7:    fp4_sig = 3'd3;
			default: fp4_sig = 3'd0;
		endcase
	endfunction

	function automatic logic [1:0] fp4_shift(input logic [2:0] code);
		case (code)
			3'd0, 3'd1: fp4_shift = 2'd0;
			3'd2:       fp4_shift = 2'd1;
			3'd3:       fp4_shift = 2'd0;
			3'd4:       fp4_shift = 2'd2;
			3'd5:       fp4_shift = 2'd1;
			3'd6:       fp4_shift = 2'd3;
			3'd7:       fp4_shift = 2'd2;
			default:    fp4_shift = 2'd0;
		endcase
	endfunction
endpackage
`default_nettype wire

### hdl/fp4dq_if.sv
`default_nettype none
interface fp4dq_if #(parameter int unsigned W = 8) (input wire logic clk);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/fp4dq_lane.sv
`default_nettype none
// One element: product of an e2m1 value and the decoded scale, as bf16 bits.
module fp4dq_lane (
	input  wire logic                [3:0] nib,
	input  wire fp4dq_pkg::scale_t         scale,
	output      fp4dq_pkg::bf16_t          res
);
	logic [2:0] vs;
	logic [1:0] vsh;
	logic [6:0] prod;
	logic [2:0] lz;
	logic [2:0] msb;
	logic [6:0] norm;
	logic [7:0] expo;

	always_comb begin
		vs   = fp4dq_pkg::fp4_sig(nib[2:0]);
		vsh  = fp4dq_pkg::fp4_shift(nib[2:0]);
		prod = {3'd0, scale.sig} * {4'd0, vs};
		msb  = 3'd0;
		for (int i = 0; i < 7; i++) begin
			if (prod[i]) msb = 3'(i);
		end
		lz   = 3'd6 - msb;
		norm = prod << lz;
		// Value is prod * 2^(vsh + scale.expo - 10); leading one sits at bit msb.
		expo = 8'd117 + 8'(msb) + 8'(vsh) + 8'(scale.expo);
		if (scale.zero || (nib[2:0] == 3'd0)) begin
			res = {nib[3] ^ scale.sign, 15'd0};
		end else begin
			res = {nib[3] ^ scale.sign, expo, norm[5:0], 1'b0};
		end
	end
endmodule
`default_nettype wire

### hdl/fp4_block_dequant_bf16.sv
`default_nettype none
// An accepted request goes to the output register, or to the skid stage on a stall.
// One request per cycle while skid is empty; sixteen element lanes work in parallel.
// A full output register and a skid stage let input accept while the output stalls.
// Reset clears the valid flags only; payload registers are not reset.
module fp4_block_dequant_bf16 #(
	parameter int unsigned BYTES_PER_BLOCK = fp4dq_pkg::BYTES_PER_BLOCK
) (
	input wire logic clk,
	input wire logic arst_n,
	fp4dq_if.sink    in_ch,
	fp4dq_if.source  out_ch
);
	localparam int unsigned NW = fp4dq_pkg::NUM_WORDS;

	fp4dq_pkg::scale_t          sc;
	logic [NW*32-1:0]           words;
	logic [NW*32-1:0]           res_s1;
	logic [NW*32-1:0]           skid_q;
	logic                       vld_s1;
	logic                       skid_vld_q;
	logic                       acc;

	always_comb begin
		sc.sign = in_ch.data[7];
		sc.zero = (in_ch.data[6:0] == 7'd0);
		if (in_ch.data[6:3] == 4'd0) begin
			sc.sig  = {1'b0, in_ch.data[2:0]};
			sc.expo = 5'd0;
		end else begin
			sc.sig  = {1'b1, in_ch.data[2:0]};
			sc.expo = {1'b0, in_ch.data[6:3]} - 5'd1;
		end
	end

	for (genvar j = 0; j < NW; j++) begin : g_word
		if (j < BYTES_PER_BLOCK) begin : g_on
			fp4dq_lane u_lo (.nib(in_ch.data[8+8*j +: 4]), .scale(sc),
				.res(words[32*j +: 16]));
			fp4dq_lane u_hi (.nib(in_ch.data[12+8*j +: 4]), .scale(sc),
				.res(words[32*j+16 +: 16]));
		end else begin : g_off
			assign words[32*j +: 32] = 32'd0;
		end
	end

	assign in_ch.ready = !skid_vld_q;
	assign acc = in_ch.valid && in_ch.ready;
	assign out_ch.valid = vld_s1;
	assign out_ch.data = res_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!vld_s1 || out_ch.ready) begin
				vld_s1     <= skid_vld_q || acc;
				skid_vld_q <= 1'b0;
			end else if (acc) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!vld_s1 || out_ch.ready) begin
			res_s1 <= skid_vld_q ? skid_q : words;
		end
		if (acc) begin
			skid_q <= words;
		end
	end

	a_skid_only_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> vld_s1) else $error("skid filled without a stall");
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !out_ch.ready |=> vld_s1) else $error("result dropped");
	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && out_ch.ready |=> !skid_vld_q) else $error("skid stuck");
endmodule
`default_nettype wire

### tb/fp4_block_dequant_bf16_test.sv
`default_nettype none
module fp4_block_dequant_bf16_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned IN_W = 8 + 8 * fp4dq_pkg::BYTES_PER_BLOCK;
	localparam int unsigned OUT_W = 32 * fp4dq_pkg::NUM_WORDS;
	localparam int unsigned RANDOM_BLOCKS = 1350;
	localparam int unsigned IDLE_LIMIT = 2000;

	typedef logic [OUT_W-1:0] words_t;

	// Expected output words for each accepted block, oldest first.
	class dequant_scoreboard;
		words_t pending[$];
		int unsigned mismatches;
		int unsigned checked;

		// Scale magnitude in units of 2^-9.
		function automatic int unsigned scale_mag(logic [7:0] sb);
			logic [3:0] ex;
			ex = sb[6:3];
			if (ex == 4'd0)
				return sb[2:0];
			return (8 + sb[2:0]) << (ex - 1);
		endfunction

		// Product in units of 2^-10 converted to bf16 with the given sign.
		function automatic fp4dq_pkg::bf16_t product_bf16(int unsigned prod, logic neg);
			int unsigned msb;
			logic [6:0] mant;
			if (prod == 0)
				return {neg, 15'd0};
			msb = 0;
			while ((prod >> (msb + 1)) != 0)
				msb++;
			if (msb >= 7)
				mant = 7'(prod >> (msb - 7));
			else
				mant = 7'(prod << (7 - msb));
			return {neg, 8'(msb + 117), mant};
		endfunction

		function automatic fp4dq_pkg::bf16_t dequant(logic [3:0] nib, logic [7:0] sb);
			int unsigned half_units[8] = '{0, 1, 2, 3, 4, 6, 8, 12};
			return product_bf16(half_units[nib[2:0]] * scale_mag(sb), nib[3] ^ sb[7]);
		endfunction

		function void note_request(logic [IN_W-1:0] data);
			words_t w;
			logic [7:0] sb;
			logic [7:0] by;
			sb = data[7:0];
			w = '0;
			for (int j = 0; j < fp4dq_pkg::NUM_WORDS; j++) begin
				if (j < fp4dq_pkg::BYTES_PER_BLOCK) begin
					by = data[8 + 8 * j +: 8];
					w[32 * j +: 32] = {dequant(by[7:4], sb), dequant(by[3:0], sb)};
				end
			end
			pending.push_back(w);
		endfunction

		function void check_result(words_t got);
			words_t want;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", got);
				return;
			end
			want = pending.pop_front();
			for (int j = 0; j < fp4dq_pkg::NUM_WORDS; j++) begin
				if (want[32 * j +: 32] !== got[32 * j +: 32]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d pair_word_%0d: expected %h, got %h",
							checked, j, want[32 * j +: 32], got[32 * j +: 32]);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	fp4dq_if #(.W(IN_W)) in_ch (.clk(clk));
	fp4dq_if #(.W(OUT_W)) out_ch (.clk(clk));

	fp4_block_dequant_bf16 u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	always #4 clk = ~clk;

	dequant_scoreboard board = new();
	bit stimulus_done = 1'b0;
	int unsigned accepted = 0;
	int unsigned idle_cycles = 0;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			board.note_request(in_ch.data);
			accepted++;
		end
		if (out_ch.valid && out_ch.ready)
			board.check_result(out_ch.data);
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles = 0;
		else if (arst_n)
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[fp4_block_dequant_bf16] ERROR");
			$finish;
		end
	end

	// Receiver: random stalls with fully open stretches, and one long hold-off
	// while the sender keeps offering requests so that the block backs up.
	initial begin
		bit held;
		int unsigned mode_left;
		bit open;
		held = 1'b0;
		open = 1'b0;
		mode_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && accepted >= 400) begin
				held = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			if (mode_left == 0) begin
				open = ($urandom_range(0, 2) == 0);
				mode_left = $urandom_range(5, 60);
			end
			mode_left--;
			out_ch.ready <= open || ($urandom_range(0, 3) != 0);
		end
	end

	task automatic offer(logic [7:0] sb, logic [63:0] bytes);
		in_ch.valid <= 1'b1;
		in_ch.data <= {bytes, sb};
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	// A zero-length pause leaves valid alone so that the next offer drives it once.
	task automatic pause(int unsigned cycles);
		if (cycles != 0) begin
			in_ch.valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	initial begin
		logic [7:0] scales[10] = '{8'h00, 8'h01, 8'h07, 8'h08, 8'h38, 8'h78, 8'h7f,
			8'h80, 8'h87, 8'hff};
		int unsigned burst;
		logic [7:0] sb;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Every nibble code against the scale extremes, including subnormal and
		// exponent-fifteen scales and zero products with both signs.
		foreach (scales[i])
			offer(scales[i], 64'hfedcba9876543210);
		foreach (scales[i])
			offer(scales[i], 64'h0123456789abcdef);
		offer(8'h00, 64'h0);
		offer(8'hff, 64'hffffffffffffffff);
		offer(8'h80, 64'h8888888888888888);
		offer(8'h7f, 64'h7777777777777777);
		pause(3);
		for (int n = 0; n < RANDOM_BLOCKS; ) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && n < RANDOM_BLOCKS; k++, n++) begin
				sb = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 7) == 0)
					sb = sb & 8'h87;
				offer(sb, {$urandom, $urandom});
			end
			pause($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
		end
		in_ch.valid <= 1'b0;
		stimulus_done = 1'b1;
	end

	initial begin
		wait (stimulus_done);
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("Ran %0d blocks through all nibble codes and scale classes,", accepted);
		$display("checked %0d results under random stalls and one long hold-off.",
			board.checked);
		if (board.mismatches == 0)
			$display("[fp4_block_dequant_bf16] OK");
		else
			$display("[fp4_block_dequant_bf16] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
